// ===== design/dbi_pkg.sv =====
// ----------------------------------------------------------------------------
// dbi_pkg: shared types and constants of the debt based backoff interval unit
// Widths, status codes, reset values and the structs between the submodules.
// ----------------------------------------------------------------------------
package dbi_pkg;

   localparam int TIME_BITS = 48;
   localparam int FRAC_BITS = 24;
   localparam int Q_BITS    = 62;
   localparam int GF_W      = 29;
   localparam int AC_W      = 32;
   localparam int DL_W      = 40;
   localparam int J_W       = 42;
   localparam int STATUS_W  = 3;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 64;

   localparam logic [1:0] REG_GROWTH = 2'd0;
   localparam logic [1:0] REG_COST   = 2'd1;
   localparam logic [1:0] REG_LIMIT  = 2'd2;

   localparam logic [GF_W-1:0] GF_RESET = GF_W'(33554432);
   localparam logic [AC_W-1:0] AC_RESET = AC_W'(60000);
   localparam logic [DL_W-1:0] DL_RESET = DL_W'(360000);

   localparam logic [GF_W-1:0] X_ONE = GF_W'(1) << FRAC_BITS;
   localparam logic [Q_BITS:0] Q_ONE = {1'b1, {Q_BITS{1'b0}}};
   localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_EARLY    = 3'd1,
      STATUS_BREACH   = 3'd2,
      STATUS_OVERFLOW = 3'd3,
      STATUS_ORDER    = 3'd4,
      STATUS_BADCFG   = 3'd5
   } status_type;

   typedef struct packed {
      logic [GF_W-1:0] growth;
      logic [AC_W-1:0] cost;
      logic [DL_W-1:0] limit;
      logic            bad;
   } cfg_type;

   typedef struct packed {
      logic            start;
      logic [DL_W-1:0] debt;
      logic [AC_W-1:0] cost;
      logic [DL_W-1:0] limit;
      logic [GF_W-1:0] growth;
   } core_req_type;

   typedef struct packed {
      logic                 done;
      logic [TIME_BITS-1:0] interval;
   } core_rsp_type;

   typedef struct packed {
      logic        go;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic         go;
      logic [127:0] num;
      logic [63:0]  den;
   } div_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] quo;
      logic [63:0]  rem;
   } div_rsp_type;

endpackage

// ===== design/dbi_ifs.sv =====
// ----------------------------------------------------------------------------
// dbi_ifs: attempt and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dbi_req_if;
   logic                           valid;
   logic                           ready;
   logic [dbi_pkg::TIME_BITS-1:0]  attempt_time;

   modport source (output valid, output attempt_time, input ready);
   modport sink   (input valid, input attempt_time, output ready);
endinterface

interface dbi_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dbi_pkg::STATUS_W-1:0]   status;
   logic [dbi_pkg::TIME_BITS-1:0]  interval;
   logic [dbi_pkg::TIME_BITS-1:0]  debt;
   logic [dbi_pkg::TIME_BITS:0]    next_time;
   logic [dbi_pkg::TIME_BITS:0]    payback_time;

   modport source (output valid, output status, output interval, output debt,
                   output next_time, output payback_time, input ready);
   modport sink   (input valid, input status, input interval, input debt,
                   input next_time, input payback_time, output ready);
endinterface

// ===== design/dbi_csr.sv =====
// ----------------------------------------------------------------------------
// dbi_csr: configuration registers
// APB-style register file for growth factor, attempt cost and debt limit.
// ----------------------------------------------------------------------------
module dbi_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dbi_pkg::CSR_AW-1:0]    paddr,
   input  logic [dbi_pkg::CSR_DW-1:0]    pwdata,
   output logic [dbi_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output dbi_pkg::cfg_type              cfg
);

   logic [dbi_pkg::GF_W-1:0] growth_ff;
   logic [dbi_pkg::AC_W-1:0] cost_ff;
   logic [dbi_pkg::DL_W-1:0] limit_ff;
   logic [1:0]               index;

   assign index  = paddr[4:3];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         growth_ff <= dbi_pkg::GF_RESET;
         cost_ff   <= dbi_pkg::AC_RESET;
         limit_ff  <= dbi_pkg::DL_RESET;
      end else if (psel && penable && pwrite) begin
         priority case (index)
            dbi_pkg::REG_GROWTH: growth_ff <= pwdata[dbi_pkg::GF_W-1:0];
            dbi_pkg::REG_COST:   cost_ff   <= pwdata[dbi_pkg::AC_W-1:0];
            dbi_pkg::REG_LIMIT:  limit_ff  <= pwdata[dbi_pkg::DL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority case (index)
         dbi_pkg::REG_GROWTH: prdata = dbi_pkg::CSR_DW'(growth_ff);
         dbi_pkg::REG_COST:   prdata = dbi_pkg::CSR_DW'(cost_ff);
         dbi_pkg::REG_LIMIT:  prdata = dbi_pkg::CSR_DW'(limit_ff);
         default:             prdata = '0;
      endcase
   end

   assign cfg.growth = growth_ff;
   assign cfg.cost   = cost_ff;
   assign cfg.limit  = limit_ff;
   assign cfg.bad    = (growth_ff < dbi_pkg::X_ONE) || (cost_ff == '0)
                       || (limit_ff < dbi_pkg::DL_W'(cost_ff));

endmodule

// ===== design/dbi_mul.sv =====
// ----------------------------------------------------------------------------
// dbi_mul: shared 64x64 multiplier
// One 32x32 multiplier, four partial products accumulated one after another.
// ----------------------------------------------------------------------------
module dbi_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  dbi_pkg::mul_req_type req,
   output dbi_pkg::mul_rsp_type rsp
);

   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [63:0]  pp_ff;
   logic [127:0] acc_ff;
   logic [31:0]  opa;
   logic [31:0]  opb;
   logic [127:0] addend;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin opa = a_ff[31:0];  opb = b_ff[31:0];  end
         2'd1: begin opa = a_ff[31:0];  opb = b_ff[63:32]; end
         2'd2: begin opa = a_ff[63:32]; opb = b_ff[31:0];  end
         default: begin opa = a_ff[63:32]; opb = b_ff[63:32]; end
      endcase
      // add the product of the previous step at its weight
      unique case (step_ff)
         3'd1:    addend = {64'b0, pp_ff};
         3'd2:    addend = {32'b0, pp_ff, 32'b0};
         3'd3:    addend = {32'b0, pp_ff, 32'b0};
         3'd4:    addend = {pp_ff, 64'b0};
         default: addend = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            a_ff    <= req.a;
            b_ff    <= req.b;
            acc_ff  <= '0;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            pp_ff   <= 64'(opa) * 64'(opb);
            acc_ff  <= acc_ff + addend;
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

// ===== design/dbi_div.sv =====
// ----------------------------------------------------------------------------
// dbi_div: shared restoring divider
// 128 by 64 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dbi_pkg::div_req_type req,
   output dbi_pkg::div_rsp_type rsp
);

   logic [127:0] n_ff;
   logic [63:0]  r_ff;
   logic [63:0]  d_ff;
   logic [6:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [63:0]  shifted;
   logic         take;

   assign shifted = {r_ff[62:0], n_ff[127]};
   assign take    = r_ff[63] || (shifted >= d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            n_ff    <= req.num;
            d_ff    <= req.den;
            r_ff    <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // shift the next dividend bit in, quotient bit in at the bottom
            r_ff   <= take ? shifted - d_ff : shifted;
            n_ff   <= {n_ff[126:0], take};
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = n_ff;
   assign rsp.rem  = r_ff;

endmodule

// ===== design/dbi_seq.sv =====
// ----------------------------------------------------------------------------
// dbi_seq: below-limit interval sequencer
// Binary search for the exponent and final division on the shared units.
// ----------------------------------------------------------------------------
module dbi_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  dbi_pkg::core_req_type creq,
   output dbi_pkg::core_rsp_type crsp,
   output dbi_pkg::mul_req_type  mreq,
   input  dbi_pkg::mul_rsp_type  mrsp,
   output dbi_pkg::div_req_type  dreq,
   input  dbi_pkg::div_rsp_type  drsp
);

   localparam int J_W = dbi_pkg::J_W;
   localparam int QB  = dbi_pkg::Q_BITS;
   localparam int FB  = dbi_pkg::FRAC_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_C_DIV, S_REM_MUL, S_INV_DIV, S_H_DIV, S_LOOP, S_N_MUL, S_POW,
      S_POW_R, S_POW_B, S_LEFT_MUL, S_RIGHT_MUL, S_F_X_MUL, S_F_P_MUL,
      S_F_DIV, S_FIN
   } state_type;

   state_type                   state_ff;
   logic [dbi_pkg::AC_W-1:0]    a_ff;
   logic [dbi_pkg::GF_W-1:0]    g_ff;
   logic [dbi_pkg::GF_W-1:0]    x1_ff;
   logic [dbi_pkg::DL_W-1:0]    nn_ff;
   logic [J_W-1:0]              c_ff;
   logic [dbi_pkg::AC_W-1:0]    rem_ff;
   logic [QB-1:0]               inv_ff;
   logic [J_W-1:0]              lo_ff;
   logic [J_W-1:0]              hi_ff;
   logic [J_W-1:0]              t_ff;
   logic [J_W-1:0]              e_ff;
   logic [63:0]                 n_ff;
   logic [QB:0]                 r_ff;
   logic [QB-1:0]               b_ff;
   logic [127:0]                left_ff;
   logic [127:0]                q1_ff;
   logic                        final_ff;
   dbi_pkg::mul_req_type        mreq_ff;
   dbi_pkg::div_req_type        dreq_ff;
   logic                        done_ff;
   logic [dbi_pkg::TIME_BITS-1:0] iv_ff;

   logic [dbi_pkg::DL_W-1:0]    nn_w;
   logic [J_W-1:0]              t_mid;
   logic [63:0]                 nval;
   logic [63:0]                 one_minus_r;
   logic [40:0]                 iv_w;

   assign nn_w        = creq.limit - creq.debt;
   assign t_mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign nval        = mrsp.prod[63:0] + 64'(rem_ff);
   assign one_minus_r = 64'(dbi_pkg::Q_ONE - r_ff);

   // round the scaled quotient up to whole time units, never below one
   always_comb begin
      iv_w = 41'(q1_ff[63:FB]) + 41'(|q1_ff[FB-1:0]);
      if (iv_w == '0) begin
         iv_w = 41'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mreq_ff.go   <= 1'b0;
         dreq_ff.go   <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         mreq_ff.go <= 1'b0;
         dreq_ff.go <= 1'b0;
         done_ff    <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (creq.start) begin
                  a_ff        <= creq.cost;
                  g_ff        <= creq.growth;
                  x1_ff       <= creq.growth - dbi_pkg::X_ONE;
                  nn_ff       <= nn_w;
                  dreq_ff.go  <= 1'b1;
                  dreq_ff.num <= 128'(41'(nn_w) + 41'(creq.cost) - 41'd1);
                  dreq_ff.den <= 64'(creq.cost);
                  state_ff    <= S_C_DIV;
               end
            end
            S_C_DIV: begin
               if (drsp.done) begin
                  c_ff       <= drsp.quo[J_W-1:0];
                  mreq_ff.go <= 1'b1;
                  mreq_ff.a  <= drsp.quo[63:0];
                  mreq_ff.b  <= 64'(a_ff);
                  state_ff   <= S_REM_MUL;
               end
            end
            S_REM_MUL: begin
               if (mrsp.done) begin
                  rem_ff      <= mrsp.prod[31:0] - nn_ff[31:0];
                  dreq_ff.go  <= 1'b1;
                  dreq_ff.num <= 128'(1) << (QB + FB);
                  dreq_ff.den <= 64'(g_ff);
                  state_ff    <= S_INV_DIV;
               end
            end
            S_INV_DIV: begin
               if (drsp.done) begin
                  inv_ff      <= drsp.quo[QB-1:0];
                  dreq_ff.go  <= 1'b1;
                  dreq_ff.num <= 128'(x1_ff + dbi_pkg::X_ONE - dbi_pkg::GF_W'(1));
                  dreq_ff.den <= 64'(x1_ff);
                  state_ff    <= S_H_DIV;
               end
            end
            S_H_DIV: begin
               if (drsp.done) begin
                  hi_ff    <= c_ff + drsp.quo[J_W-1:0];
                  lo_ff    <= c_ff - J_W'(1);
                  state_ff <= S_LOOP;
               end
            end
            S_LOOP: begin
               if (lo_ff < hi_ff) begin
                  t_ff     <= t_mid;
                  final_ff <= 1'b0;
                  if (t_mid < c_ff) begin
                     lo_ff <= t_mid + J_W'(1);
                  end else begin
                     mreq_ff.go <= 1'b1;
                     mreq_ff.a  <= 64'(t_mid - c_ff);
                     mreq_ff.b  <= 64'(a_ff);
                     state_ff   <= S_N_MUL;
                  end
               end else begin
                  t_ff       <= hi_ff;
                  final_ff   <= 1'b1;
                  mreq_ff.go <= 1'b1;
                  mreq_ff.a  <= 64'(hi_ff - c_ff);
                  mreq_ff.b  <= 64'(a_ff);
                  state_ff   <= S_N_MUL;
               end
            end
            S_N_MUL: begin
               if (mrsp.done) begin
                  if (nval == '0 && !final_ff) begin
                     lo_ff    <= t_ff + J_W'(1);
                     state_ff <= S_LOOP;
                  end else begin
                     n_ff     <= nval;
                     r_ff     <= dbi_pkg::Q_ONE;
                     b_ff     <= inv_ff;
                     e_ff     <= t_ff;
                     state_ff <= S_POW;
                  end
               end
            end
            S_POW: begin
               mreq_ff.go <= 1'b1;
               if (e_ff == '0) begin
                  mreq_ff.a <= n_ff;
                  mreq_ff.b <= 64'(x1_ff);
                  state_ff  <= final_ff ? S_F_X_MUL : S_LEFT_MUL;
               end else if (e_ff[0]) begin
                  mreq_ff.a <= 64'(r_ff);
                  mreq_ff.b <= 64'(b_ff);
                  state_ff  <= S_POW_R;
               end else begin
                  mreq_ff.a <= 64'(b_ff);
                  mreq_ff.b <= 64'(b_ff);
                  state_ff  <= S_POW_B;
               end
            end
            S_POW_R: begin
               if (mrsp.done) begin
                  r_ff       <= mrsp.prod[QB+QB:QB];
                  mreq_ff.go <= 1'b1;
                  mreq_ff.a  <= 64'(b_ff);
                  mreq_ff.b  <= 64'(b_ff);
                  state_ff   <= S_POW_B;
               end
            end
            S_POW_B: begin
               if (mrsp.done) begin
                  b_ff     <= mrsp.prod[QB+QB-1:QB];
                  e_ff     <= e_ff >> 1;
                  state_ff <= S_POW;
               end
            end
            S_LEFT_MUL: begin
               if (mrsp.done) begin
                  left_ff    <= mrsp.prod << (QB - FB);
                  mreq_ff.go <= 1'b1;
                  mreq_ff.a  <= 64'(a_ff);
                  mreq_ff.b  <= one_minus_r;
                  state_ff   <= S_RIGHT_MUL;
               end
            end
            S_RIGHT_MUL: begin
               if (mrsp.done) begin
                  if (left_ff <= mrsp.prod) begin
                     lo_ff <= t_ff + J_W'(1);
                  end
                  if (left_ff >= mrsp.prod) begin
                     hi_ff <= t_ff;
                  end
                  state_ff <= S_LOOP;
               end
            end
            S_F_X_MUL: begin
               if (mrsp.done) begin
                  mreq_ff.go <= 1'b1;
                  mreq_ff.a  <= mrsp.prod[63:0];
                  mreq_ff.b  <= 64'(r_ff);
                  state_ff   <= S_F_P_MUL;
               end
            end
            S_F_P_MUL: begin
               if (mrsp.done) begin
                  dreq_ff.go  <= 1'b1;
                  dreq_ff.num <= mrsp.prod;
                  dreq_ff.den <= one_minus_r;
                  state_ff    <= S_F_DIV;
               end
            end
            S_F_DIV: begin
               if (drsp.done) begin
                  q1_ff    <= drsp.quo + 128'(drsp.rem != '0);
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               done_ff  <= 1'b1;
               iv_ff    <= (q1_ff[127:64] != '0) ? dbi_pkg::TIME_MASK
                                                 : dbi_pkg::TIME_BITS'(iv_w);
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign mreq          = mreq_ff;
   assign dreq          = dreq_ff;
   assign crsp.done     = done_ff;
   assign crsp.interval = iv_ff;

endmodule

// ===== design/debt_based_backoff_interval_unit.sv =====
// ----------------------------------------------------------------------------
// debt_based_backoff_interval_unit: debt based backoff interval
// Tracks attempt debt and recommends the wait before the next attempt.
// ----------------------------------------------------------------------------
// Path: rejected attempts pass T_DECAY and T_EMIT before the output register;
//   saturated, breach, limit and unit-factor ones also pass T_CLASS. Below the
//   limit add T_CORE with four divisions, multiplies and the binary search
//   steps of the sequencer on the shared units.
// Throughput: one attempt at a time; the next transfer is taken once the
//   result sits in the output register. Sync reset clears state, no sweep.
module debt_based_backoff_interval_unit (
   input  logic                       clock,
   input  logic                       reset,
   dbi_req_if.sink                    req_if,
   dbi_rsp_if.source                  rsp_if,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [dbi_pkg::CSR_AW-1:0] paddr,
   input  logic [dbi_pkg::CSR_DW-1:0] pwdata,
   output logic [dbi_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);

   localparam int TB = dbi_pkg::TIME_BITS;

   typedef enum logic [2:0] {T_IDLE, T_DECAY, T_CLASS, T_CORE, T_EMIT} state_type;

   dbi_pkg::cfg_type      cfg;
   dbi_pkg::core_req_type creq;
   dbi_pkg::core_rsp_type crsp;
   dbi_pkg::mul_req_type  mreq;
   dbi_pkg::mul_rsp_type  mrsp;
   dbi_pkg::div_req_type  dreq;
   dbi_pkg::div_rsp_type  drsp;

   state_type             state_ff;
   logic [TB-1:0]         t_ff;
   logic [TB:0]           d_ff;
   dbi_pkg::status_type   status_ff;
   logic [TB-1:0]         last_time_ff;
   logic                  has_prior_ff;
   logic [TB-1:0]         debt_ff;
   logic [TB-1:0]         interval_ff;
   logic                  start_ff;
   logic                  rsp_valid_ff;
   dbi_pkg::status_type   rsp_status_ff;
   logic [TB-1:0]         rsp_interval_ff;
   logic [TB-1:0]         rsp_debt_ff;
   logic [TB:0]           rsp_next_ff;
   logic [TB:0]           rsp_payback_ff;

   logic [TB-1:0]         diff;
   logic [TB-1:0]         decayed;
   logic [TB-1:0]         excess;
   logic                  load_rsp;

   dbi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dbi_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));
   dbi_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   dbi_seq u_seq (
      .clock (clock),
      .reset (reset),
      .creq  (creq),
      .crsp  (crsp),
      .mreq  (mreq),
      .mrsp  (mrsp),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   assign creq.start  = start_ff;
   assign creq.debt   = d_ff[dbi_pkg::DL_W-1:0];
   assign creq.cost   = cfg.cost;
   assign creq.limit  = cfg.limit;
   assign creq.growth = cfg.growth;

   // debt decays by the elapsed time, never below zero
   assign diff    = t_ff - last_time_ff;
   assign decayed = (has_prior_ff && diff < debt_ff) ? debt_ff - diff : '0;
   // distance the debt must fall back to: L - A
   assign excess  = TB'(cfg.limit - dbi_pkg::DL_W'(cfg.cost));

   assign req_if.ready = (state_ff == T_IDLE);
   assign load_rsp     = (state_ff == T_EMIT) && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         last_time_ff <= '0;
         has_prior_ff <= 1'b0;
         debt_ff      <= '0;
         interval_ff  <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (req_if.valid) begin
                  t_ff     <= req_if.attempt_time;
                  state_ff <= T_DECAY;
               end
            end
            T_DECAY: begin
               // config check first, then time order
               priority if (cfg.bad) begin
                  status_ff <= dbi_pkg::STATUS_BADCFG;
                  state_ff  <= T_EMIT;
               end else if (has_prior_ff && t_ff < last_time_ff) begin
                  status_ff <= dbi_pkg::STATUS_ORDER;
                  state_ff  <= T_EMIT;
               end else begin
                  status_ff <= (has_prior_ff && diff < interval_ff)
                               ? dbi_pkg::STATUS_EARLY : dbi_pkg::STATUS_OK;
                  d_ff      <= (TB+1)'(decayed) + (TB+1)'(cfg.cost);
                  state_ff  <= T_CLASS;
               end
            end
            T_CLASS: begin
               priority if (d_ff[TB]) begin
                  // saturate the debt and warn of overflow
                  status_ff    <= dbi_pkg::STATUS_OVERFLOW;
                  debt_ff      <= dbi_pkg::TIME_MASK;
                  interval_ff  <= dbi_pkg::TIME_MASK - excess;
                  last_time_ff <= t_ff;
                  has_prior_ff <= 1'b1;
                  state_ff     <= T_EMIT;
               end else if (d_ff < (TB+1)'(cfg.limit)
                            && cfg.growth > dbi_pkg::X_ONE) begin
                  start_ff <= 1'b1;
                  state_ff <= T_CORE;
               end else if (d_ff <= (TB+1)'(cfg.limit)) begin
                  // unit factor or debt right at the limit
                  debt_ff      <= d_ff[TB-1:0];
                  interval_ff  <= TB'(cfg.cost);
                  last_time_ff <= t_ff;
                  has_prior_ff <= 1'b1;
                  state_ff     <= T_EMIT;
               end else begin
                  status_ff    <= dbi_pkg::STATUS_BREACH;
                  debt_ff      <= d_ff[TB-1:0];
                  interval_ff  <= d_ff[TB-1:0] - excess;
                  last_time_ff <= t_ff;
                  has_prior_ff <= 1'b1;
                  state_ff     <= T_EMIT;
               end
            end
            T_CORE: begin
               if (crsp.done) begin
                  debt_ff      <= d_ff[TB-1:0];
                  interval_ff  <= crsp.interval;
                  last_time_ff <= t_ff;
                  has_prior_ff <= 1'b1;
                  state_ff     <= T_EMIT;
               end
            end
            T_EMIT: begin
               // hold until the output register is free, then report state
               if (load_rsp) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= status_ff;
                  rsp_interval_ff <= interval_ff;
                  rsp_debt_ff     <= debt_ff;
                  rsp_next_ff     <= (TB+1)'(last_time_ff) + (TB+1)'(interval_ff);
                  rsp_payback_ff  <= (TB+1)'(last_time_ff) + (TB+1)'(debt_ff);
                  state_ff        <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.interval     = rsp_interval_ff;
   assign rsp_if.debt         = rsp_debt_ff;
   assign rsp_if.next_time    = rsp_next_ff;
   assign rsp_if.payback_time = rsp_payback_ff;

endmodule
